[hdl/dad_pkg.sv]
// ----------------------------------------------------------------------------
// dad_pkg
// shared constants, types and calendar helpers for the packed date adder
// ----------------------------------------------------------------------------
`default_nettype none

package dad_pkg;

   localparam int unsigned DateW = 27;
   localparam int unsigned AddW  = 32;
   localparam int unsigned ResW  = 25;
   localparam int unsigned SerW  = 20;

   // packed dates bounding years 1980..2200
   localparam logic [26:0] DateLo = 27'd19800000;
   localparam logic [26:0] DateHi = 27'd22009999;

   localparam logic [10:0] YearBase = 11'd1980;
   localparam logic [7:0]  YearSpan = 8'd220;

   // serial of 1979-12-31, of 1980-01-01 and of 2200-12-31
   localparam logic [19:0] SerBase  = 20'd722814;
   localparam logic [19:0] SerFirst = 20'd722815;
   localparam logic [19:0] SerLast  = 20'd803533;

   // reciprocal constants
   localparam int unsigned   DivYK = 35;
   localparam longint unsigned DivYFull = ((64'd1 << DivYK) + 64'd9999) / 64'd10000;
   localparam logic [21:0]   DivYM = 22'(DivYFull);
   localparam int unsigned   DivMK = 27;
   localparam longint unsigned DivMFull = ((64'd1 << DivMK) + 64'd99) / 64'd100;
   localparam logic [20:0]   DivMM = 21'(DivMFull);
   localparam int unsigned   DivQK = 30;
   localparam longint unsigned DivQFull = ((64'd1 << DivQK) + 64'd1460) / 64'd1461;
   localparam logic [19:0]   DivQM = 20'(DivQFull);

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic [19:0] serial;
      logic [31:0] add;
   } mid_type;

   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] r;
      case (m)
         4'd2:    r = 5'd28;
         4'd4:    r = 5'd30;
         4'd6:    r = 5'd30;
         4'd9:    r = 5'd30;
         4'd11:   r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

   // leap year by offset from 1980
   function automatic logic leap_off(input logic [7:0] yo);
      return (yo[1:0] == 2'd0) && (yo != 8'd120) && (yo != 8'd220);
   endfunction

   // day offset of 1 january of year 1980+yo from 1980-01-01
   function automatic logic [16:0] start_of(input logic [8:0] yo);
      logic [16:0] base;
      logic [6:0]  lc;
      base = 17'(yo) * 17'd365;
      lc   = 7'((yo + 9'd3) >> 2);
      return base + 17'(lc) - 17'(yo > 9'd120);
   endfunction

endpackage

`default_nettype wire

[hdl/dad_if.sv]
// ----------------------------------------------------------------------------
// dad_if
// request and response channel interfaces of the packed date adder
// ----------------------------------------------------------------------------
`default_nettype none

interface dad_req_if;
   logic        valid;
   logic        ready;
   logic [26:0] date_in;
   logic [31:0] day_count;
   modport source (output valid, output date_in, output day_count, input ready);
   modport sink   (input valid, input date_in, input day_count, output ready);
endinterface

interface dad_rsp_if;
   logic        valid;
   logic        ready;
   logic [24:0] result_date;
   logic        date_valid;
   logic [19:0] date_serial;
   modport source (output valid, output result_date, output date_valid,
                   output date_serial, input ready);
   modport sink   (input valid, input result_date, input date_valid,
                   input date_serial, output ready);
endinterface

`default_nettype wire

[hdl/dad_split.sv]
// ----------------------------------------------------------------------------
// dad_split
// five stages: split the packed date, check it and form its day serial
// ----------------------------------------------------------------------------
`default_nettype none

module dad_split (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_valid,
   input  wire logic [26:0]    date_in,
   input  wire logic [31:0]    day_count,
   output dad_pkg::mid_type    mid_out
);

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic        s1_inr_ff, s2_inr_ff, s3_inr_ff, s4_inr_ff;
   logic [21:0] s1_x_ff, s2_x_ff;
   logic [31:0] s1_add_ff, s2_add_ff, s3_add_ff, s4_add_ff, s5_add_ff;
   logic [7:0]  s2_yoff_ff, s3_yoff_ff, s4_yoff_ff;
   logic [13:0] s3_r_ff, s4_r_ff;
   logic [6:0]  s4_mo_ff;
   logic        s5_ok_ff;
   logic [19:0] s5_serial_ff;

   logic        s1_inr_in;
   logic [21:0] s1_x_in;
   logic [43:0] y_prod;
   logic [7:0]  s2_yoff_in;
   logic [21:0] y_mul;
   logic [13:0] s3_r_in;
   logic [34:0] m_prod;
   logic [6:0]  s4_mo_in;
   logic [13:0] m_mul;
   logic [6:0]  dd;
   logic        lp;
   logic [4:0]  mlen;
   logic        s5_ok_in;
   logic [19:0] s5_serial_in;

   always_comb begin
      s1_inr_in  = (date_in >= dad_pkg::DateLo) && (date_in <= dad_pkg::DateHi);
      s1_x_in    = 22'(date_in - dad_pkg::DateLo);
      y_prod     = 44'(s1_x_ff) * 44'(dad_pkg::DivYM);
      s2_yoff_in = y_prod[dad_pkg::DivYK +: 8];
      y_mul      = 22'(s2_yoff_ff) * 22'd10000;
      s3_r_in    = 14'(s2_x_ff - y_mul);
      m_prod     = 35'(s3_r_ff) * 35'(dad_pkg::DivMM);
      s4_mo_in   = m_prod[dad_pkg::DivMK +: 7];
      m_mul      = 14'(s4_mo_ff) * 14'd100;
      dd         = 7'(s4_r_ff - m_mul);
      lp         = dad_pkg::leap_off(s4_yoff_ff);
      mlen       = dad_pkg::month_len(s4_mo_ff[3:0]) +
                   5'(lp && (s4_mo_ff == 7'd2));
      s5_ok_in   = s4_inr_ff && (s4_mo_ff >= 7'd1) && (s4_mo_ff <= 7'd12) &&
                   (dd >= 7'd1) && (dd <= 7'(mlen));
      s5_serial_in = dad_pkg::SerBase
                   + 20'(dad_pkg::start_of({1'b0, s4_yoff_ff}))
                   + 20'(dad_pkg::month_start(s4_mo_ff[3:0]))
                   + 20'(lp && (s4_mo_ff > 7'd2))
                   + 20'(dd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_inr_ff    <= s1_inr_in;
         s1_x_ff      <= s1_x_in;
         s1_add_ff    <= day_count;
         s2_inr_ff    <= s1_inr_ff;
         s2_x_ff      <= s1_x_ff;
         s2_add_ff    <= s1_add_ff;
         s2_yoff_ff   <= s2_yoff_in;
         s3_inr_ff    <= s2_inr_ff;
         s3_add_ff    <= s2_add_ff;
         s3_yoff_ff   <= s2_yoff_ff;
         s3_r_ff      <= s3_r_in;
         s4_inr_ff    <= s3_inr_ff;
         s4_add_ff    <= s3_add_ff;
         s4_yoff_ff   <= s3_yoff_ff;
         s4_r_ff      <= s3_r_ff;
         s4_mo_ff     <= s4_mo_in;
         s5_ok_ff     <= s5_ok_in;
         s5_serial_ff <= s5_ok_in ? s5_serial_in : 20'd0;
         s5_add_ff    <= s4_add_ff;
      end
   end

   assign mid_out.valid  = s5_valid_ff;
   assign mid_out.ok     = s5_ok_ff;
   assign mid_out.serial = s5_serial_ff;
   assign mid_out.add    = s5_add_ff;

   a_serial_span: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && s5_ok_ff |->
         (s5_serial_ff >= dad_pkg::SerFirst) && (s5_serial_ff <= dad_pkg::SerLast))
      else $error("serial of a valid date out of span");

   a_bad_serial_zero: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && !s5_ok_ff |-> s5_serial_ff == 20'd0)
      else $error("invalid date with nonzero serial");

   a_year_quot: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_inr_ff |-> (s3_yoff_ff <= dad_pkg::YearSpan) && (s3_r_ff < 14'd10000))
      else $error("year split out of range");

endmodule

`default_nettype wire

[hdl/dad_conv.sv]
// ----------------------------------------------------------------------------
// dad_conv
// five stages: add the day count and turn the sum back into a packed date
// ----------------------------------------------------------------------------
`default_nettype none

module dad_conv (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dad_pkg::mid_type mid_in,
   input  wire logic             rsp_ready,
   output logic                  en,
   output logic                  rsp_valid,
   output logic [24:0]           result_date,
   output logic                  date_valid,
   output logic [19:0]           date_serial
);

   logic        s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff, s10_valid_ff;
   logic        s6_ok_ff, s7_ok_ff, s8_ok_ff, s9_ok_ff, s10_ok_ff;
   logic        s6_inr_ff, s7_inr_ff, s8_inr_ff, s9_inr_ff;
   logic [19:0] s6_ser_ff, s7_ser_ff, s8_ser_ff, s9_ser_ff, s10_ser_ff;
   logic [16:0] s6_t_ff, s7_t_ff;
   logic [7:0]  s7_e_ff, s8_y_ff, s9_y_ff;
   logic [8:0]  s8_doy_ff;
   logic [3:0]  s9_m_ff;
   logic [4:0]  s9_d_ff;
   logic [24:0] s10_res_ff;

   logic [32:0] sum;
   logic        s6_inr_in;
   logic [16:0] s6_t_in;
   logic [38:0] q_prod;
   logic [8:0]  e_raw;
   logic [7:0]  s7_e_in;
   logic [16:0] st0, st1, stm;
   logic [7:0]  s8_y_in;
   logic [16:0] doy_w;
   logic        lp;
   logic [3:0]  s9_m_in;
   logic [9:0]  thr;
   logic [9:0]  base_m;
   logic [4:0]  s9_d_in;
   logic [24:0] s10_res_in;

   assign en = !s10_valid_ff || rsp_ready;

   always_comb begin
      sum       = 33'(mid_in.serial) + 33'(mid_in.add);
      s6_inr_in = mid_in.ok && (sum <= 33'(dad_pkg::SerLast));
      s6_t_in   = 17'(sum - 33'(dad_pkg::SerFirst));

      q_prod  = 39'({s6_t_ff, 2'b00}) * 39'(dad_pkg::DivQM);
      e_raw   = q_prod[dad_pkg::DivQK +: 9];
      s7_e_in = (e_raw > 9'(dad_pkg::YearSpan)) ? dad_pkg::YearSpan : e_raw[7:0];

      st0 = dad_pkg::start_of({1'b0, s7_e_ff});
      st1 = dad_pkg::start_of(9'(s7_e_ff) + 9'd1);
      stm = dad_pkg::start_of(9'(s7_e_ff) - 9'd1);
      if ((s7_e_ff < dad_pkg::YearSpan) && (s7_t_ff >= st1)) begin
         s8_y_in = s7_e_ff + 8'd1;
         doy_w   = s7_t_ff - st1;
      end else if ((s7_t_ff < st0) && (s7_e_ff != 8'd0)) begin
         s8_y_in = s7_e_ff - 8'd1;
         doy_w   = s7_t_ff - stm;
      end else begin
         s8_y_in = s7_e_ff;
         doy_w   = s7_t_ff - st0;
      end

      lp      = dad_pkg::leap_off(s8_y_ff);
      s9_m_in = 4'd1;
      for (int i = 2; i <= 12; i++) begin
         thr = 10'(dad_pkg::month_start(4'(i))) + 10'(lp && (i > 2));
         if ({1'b0, s8_doy_ff} >= thr) begin
            s9_m_in = 4'(i);
         end
      end
      base_m  = 10'(dad_pkg::month_start(s9_m_in)) + 10'(lp && (s9_m_in > 4'd2));
      s9_d_in = 5'({1'b0, s8_doy_ff} - base_m + 10'd1);

      s10_res_in = (25'(s9_y_ff) + 25'(dad_pkg::YearBase)) * 25'd10000
                 + 25'(25'(s9_m_ff) * 25'd100) + 25'(s9_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff  <= mid_in.valid;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ok_ff   <= mid_in.ok;
         s6_ser_ff  <= mid_in.serial;
         s6_inr_ff  <= s6_inr_in;
         s6_t_ff    <= s6_t_in;
         s7_ok_ff   <= s6_ok_ff;
         s7_ser_ff  <= s6_ser_ff;
         s7_inr_ff  <= s6_inr_ff;
         s7_t_ff    <= s6_t_ff;
         s7_e_ff    <= s7_e_in;
         s8_ok_ff   <= s7_ok_ff;
         s8_ser_ff  <= s7_ser_ff;
         s8_inr_ff  <= s7_inr_ff;
         s8_y_ff    <= s8_y_in;
         s8_doy_ff  <= 9'(doy_w);
         s9_ok_ff   <= s8_ok_ff;
         s9_ser_ff  <= s8_ser_ff;
         s9_inr_ff  <= s8_inr_ff;
         s9_y_ff    <= s8_y_ff;
         s9_m_ff    <= s9_m_in;
         s9_d_ff    <= s9_d_in;
         s10_ok_ff  <= s9_ok_ff;
         s10_ser_ff <= s9_ser_ff;
         s10_res_ff <= s9_inr_ff ? s10_res_in : 25'd0;
      end
   end

   assign rsp_valid   = s10_valid_ff;
   assign result_date = s10_res_ff;
   assign date_valid  = s10_ok_ff;
   assign date_serial = s10_ser_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      s10_valid_ff && !s10_ok_ff |-> (s10_res_ff == 25'd0) && (s10_ser_ff == 20'd0))
      else $error("invalid date gives nonzero result");

   a_doy_range: assert property (@(posedge clock) disable iff (reset)
      s8_valid_ff && s8_inr_ff |-> (s8_doy_ff < 9'd366) && (s8_y_ff <= dad_pkg::YearSpan))
      else $error("year search missed");

   a_month_day: assert property (@(posedge clock) disable iff (reset)
      s9_valid_ff && s9_inr_ff |->
         (s9_m_ff >= 4'd1) && (s9_m_ff <= 4'd12) && (s9_d_ff >= 5'd1))
      else $error("month walk out of range");

endmodule

`default_nettype wire

[hdl/packed_date_add_days.sv]
// ----------------------------------------------------------------------------
// packed_date_add_days
// adds a day count to a packed YYYYMMDD date, years 1980 to 2200
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_ch    in         date_in, day_count
//  rsp_ch    out        result_date, date_valid, date_serial
//
//  ten register stages, one transfer in each cycle while the response is taken or the last stage is empty
//  the stage count is set by the three reciprocal multiplies and the year search
//  reset clears the stage valid bits only
//  a held response stalls every stage together; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module packed_date_add_days (
   input  wire logic  clock,
   input  wire logic  reset,
   dad_req_if.sink    req_ch,
   dad_rsp_if.source  rsp_ch
);

   logic             en;
   dad_pkg::mid_type mid;

   assign req_ch.ready = en;

   dad_split u_split (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .date_in   (req_ch.date_in),
      .day_count (req_ch.day_count),
      .mid_out   (mid)
   );

   dad_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .mid_in      (mid),
      .rsp_ready   (rsp_ch.ready),
      .en          (en),
      .rsp_valid   (rsp_ch.valid),
      .result_date (rsp_ch.result_date),
      .date_valid  (rsp_ch.date_valid),
      .date_serial (rsp_ch.date_serial)
   );

endmodule

`default_nettype wire

[tb/dad_checker.sv]
// ----------------------------------------------------------------------------
// dad_checker
// watches both channels of the packed date adder, predicts each response from
// the accepted request and compares the whole response with it, in order
// ----------------------------------------------------------------------------
`default_nettype none

module dad_checker (
   input  wire logic clock,
   input  wire logic reset,
   dad_req_if        req_ch,
   dad_rsp_if        rsp_ch,
   output int        fail_count,
   output int        pending_count,
   output int        transfer_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [24:0] result_date;
      logic        date_valid;
      logic [19:0] date_serial;
   } date_result_t;

   date_result_t pending_results[$];
   int           mismatch_count;

   function automatic bit is_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
      int unsigned len_tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && is_leap(y)) return 29;
      return len_tab[m - 1];
   endfunction

   function automatic longint unsigned day_serial(input int unsigned y, input int unsigned m,
                                                  input int unsigned d);
      int unsigned      start_tab[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                          304, 334};
      longint unsigned  p;
      longint unsigned  s;
      p = y - 1;
      s = p * 365 + p / 4 - p / 100 + p / 400 + start_tab[m - 1];
      if (m > 2 && is_leap(y)) s++;
      return s + d;
   endfunction

   function automatic date_result_t add_to_date(input logic [26:0] date_in,
                                                input logic [31:0] day_count);
      date_result_t    r;
      int unsigned     y, m, d;
      longint unsigned s, sum, doy;
      r = '0;
      y = date_in / 10000;
      m = (date_in / 100) % 100;
      d = date_in % 100;
      if (y < 1980 || y > 2200 || m < 1 || m > 12 || d < 1) return r;
      if (d > month_days(y, m)) return r;
      s = day_serial(y, m, d);
      r.date_valid  = 1'b1;
      r.date_serial = 20'(s);
      sum = s + longint'(day_count);
      if (sum > day_serial(2200, 12, 31)) return r;
      y = 1980;
      while (y < 2200 && day_serial(y + 1, 1, 1) <= sum) y++;
      doy = sum - day_serial(y, 1, 1) + 1;
      for (m = 1; m <= 12; m++) begin
         if (doy <= month_days(y, m)) begin
            r.result_date = 25'(y * 10000 + m * 100 + doy);
            return r;
         end
         doy -= month_days(y, m);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      date_result_t expected, actual;
      if (reset) begin
         pending_results.delete();
         fail_count     <= 0;
         mismatch_count = 0;
         transfer_count <= 0;
         pending_count  <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            pending_results.push_back(add_to_date(req_ch.date_in, req_ch.day_count));
         if (rsp_ch.valid && rsp_ch.ready) begin
            transfer_count <= transfer_count + 1;
            actual = '{rsp_ch.result_date, rsp_ch.date_valid, rsp_ch.date_serial};
            if (pending_results.size() == 0) begin
               fail_count <= fail_count + 1;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response %h", actual);
            end else begin
               expected = pending_results.pop_front();
               if (actual !== expected) begin
                  fail_count <= fail_count + 1;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected date %0d valid %0d serial %0d, got %0d %0d %0d",
                              expected.result_date, expected.date_valid,
                              expected.date_serial, actual.result_date,
                              actual.date_valid, actual.date_serial);
               end
            end
         end
         pending_count <= pending_results.size();
      end
   end

endmodule

`default_nettype wire

[tb/packed_date_add_days_tb.sv]
// ----------------------------------------------------------------------------
// packed_date_add_days_tb
// directed and random dates and day counts, random gaps on both sides,
// a long response hold-off and a drain pause; verdict from the checker count
// ----------------------------------------------------------------------------
`default_nettype none

module packed_date_add_days_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 5000;

   logic clock;
   logic reset;
   int   fail_count, pending_count, transfer_count;
   int   idle_cycles;
   bit   sending_done;
   bit   hold_off;

   dad_req_if req_ch ();
   dad_rsp_if rsp_ch ();

   packed_date_add_days uut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   dad_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .fail_count(fail_count), .pending_count(pending_count),
      .transfer_count(transfer_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [26:0] valid_date();
      int unsigned y, m, d, dmax;
      y = $urandom_range(2200, 1980);
      m = $urandom_range(12, 1);
      dmax = (m == 2) ? (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0) ? 29 : 28)
           : (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
      d = ($urandom_range(3) == 0) ? dmax : $urandom_range(dmax, 1);
      return 27'(y * 10000 + m * 100 + d);
   endfunction

   function automatic logic [31:0] random_days();
      case ($urandom_range(5))
         0:       return $urandom();
         1:       return $urandom_range(80718, 80000);
         2:       return $urandom_range(40);
         default: return $urandom_range(90000);
      endcase
   endfunction

   task automatic send_date(input logic [26:0] date_in, input logic [31:0] day_count,
                            input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.date_in   <= date_in;
      req_ch.day_count <= day_count;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [26:0] directed_dates[] = '{
         27'd19800101, 27'd22001231, 27'd19791231, 27'd22010101, 27'd0,
         27'd99999999, 27'h7FFFFFF, 27'd20000229, 27'd21000229, 27'd19840229,
         27'd19850229, 27'd20240431, 27'd20240100, 27'd20241301, 27'd20240001,
         27'd20241232, 27'd19991231, 27'd20001231, 27'd21000228, 27'd22000228
      };
      logic [31:0] directed_days[] = '{
         32'd0, 32'd0, 32'd5, 32'd1, 32'd0,
         32'd0, 32'hFFFFFFFF, 32'd366, 32'd1, 32'd1,
         32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
         32'd1, 32'd80718, 32'd1, 32'd1, 32'hFFFFFFFF
      };
      req_ch.valid     <= 1'b0;
      req_ch.date_in   <= '0;
      req_ch.day_count <= '0;
      sending_done     = 1'b0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_dates[i]) send_date(directed_dates[i], directed_days[i], 1'b0);
      send_date(27'd19800101, 32'd80718, 1'b0);
      send_date(27'd19800101, 32'd80719, 1'b0);
      send_date(27'd22001231, 32'd1, 1'b0);
      wait_drained();
      for (int i = 0; i < 400; i++) begin
         if (i == 200) wait_drained();
         if (i >= 100 && i < 140)
            send_date(valid_date(), random_days(), 1'b1);
         else if ($urandom_range(9) < 8)
            send_date(valid_date(), random_days(), i > 300);
         else
            send_date(27'($urandom_range(27'h7FFFFFF)), $urandom(), 1'b0);
      end
      req_ch.valid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      hold_off = 1'b0;
      @(negedge reset);
      forever begin
         if (transfer_count >= 100 && !hold_off) begin
            hold_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (60) @(posedge clock);
         end
         stall = (transfer_count > 300) ? 0 : $urandom_range(11);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
         end
         if (sending_done && pending_count == 0) begin
            repeat (20) @(posedge clock);
            if (fail_count == 0 && pending_count == 0)
               $display("All tests passed");
            else
               $display("Some tests failed");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
